// File: design/fixed_block_pool_allocator_assert.svh
// assertion macros shared by the allocator rtl
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FBPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define FBPA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fbpa_pkg.sv
package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned STRIDE_W       = 16;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned ADDR_BUS_W     = 32;
  localparam int unsigned ACT_W          = 2;
  localparam int unsigned STAT_W         = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [ADDR_BUS_W-1:0] BASE_RST   = '0;
  localparam logic [STRIDE_W-1:0]   STRIDE_RST = 16'd64;
  localparam logic [COUNT_W-1:0]    COUNT_RST  = 11'd1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE   = 2'd0,
    CFG_STRIDE = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } fbpa_div_sts_t;

endpackage

// File: design/fbpa_ram.sv
module fbpa_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fbpa_div.sv
module fbpa_div import fbpa_pkg::*; #(
  parameter int unsigned QUO_W = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [STRIDE_W+QUO_W-1:0] dividend_i,
  input  logic [STRIDE_W-1:0]       divisor_i,
  output fbpa_div_sts_t             sts_o,
  output logic [QUO_W-1:0]          quotient_o,
  output logic [STRIDE_W+QUO_W-1:0] remainder_o
);

  localparam int unsigned DIV_W = STRIDE_W + QUO_W;
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic             ge;

  // quotient is known to fit in QUO_W bits, so the divisor starts at bit QUO_W-1
  assign ge = (rem_q >= den_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      rem_d  = dividend_i;
      den_d  = DIV_W'(divisor_i) << (QUO_W - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - den_q;
      end
      quo_d = QUO_W'({quo_q, ge});
      den_d = den_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: design/fixed_block_pool_allocator.sv
// channel   | direction | handshake                  | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser action, tdata size + address
// m_axis    | out       | m_axis_tvalid/m_axis_tready | tuser status, tdata block address
// cfg       | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one item at a time; s_axis_tready is high only while the sequencer is idle
// init: one link written per cycle for each used block, then response
// alloc: link read, index times stride, add base, response
// free: range check, then the shift-subtract divider (one quotient bit per cycle), response
// a result waits in S_RESP while an older one is unaccepted; rst_ni empties the pool
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,   // request_size[15:0], free_address[47:16]
  input  logic [ACT_W-1:0]      s_axis_tuser,   // action[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ADDR_BUS_W-1:0] m_axis_tdata,   // block_address[31:0]
  output logic [STAT_W-1:0]     m_axis_tuser,   // status[1:0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_BLOCKS);
  localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PROD_W = LINK_W + STRIDE_W;
  localparam int unsigned DIV_W  = STRIDE_W + ADDR_W;
  localparam int unsigned CMP_W  = (PROD_W > ADDR_BUS_W) ? PROD_W : ADDR_BUS_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_AREAD = 3'd2;
  localparam logic [2:0] S_AADD  = 3'd3;
  localparam logic [2:0] S_FRNG  = 3'd4;
  localparam logic [2:0] S_FDIV  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [LINK_W-1:0]     head_q, head_d;
  logic [LINK_W-1:0]     cnt_q, cnt_d;
  logic [ADDR_BUS_W-1:0] base_q;
  logic [STRIDE_W-1:0]   stride_q;
  logic [COUNT_W-1:0]    count_q;
  logic [ADDR_BUS_W-1:0] off_q;
  logic                  lt_q;
  logic [PROD_W-1:0]     prod_q;
  logic [STAT_W-1:0]     res_status_q, res_status_d;
  logic [ADDR_BUS_W-1:0] res_addr_q, res_addr_d;
  logic                  m_valid_q, m_valid_d;
  logic [STAT_W-1:0]     m_status_q, m_status_d;
  logic [ADDR_BUS_W-1:0] m_addr_q, m_addr_d;

  action_e               act;
  logic [STRIDE_W-1:0]   req_size;
  logic [ADDR_BUS_W-1:0] free_addr;
  logic                  in_acc;
  logic [LINK_W-1:0]     used;
  logic [LINK_W-1:0]     cnt_inc;
  logic [LINK_W-1:0]     init_link;
  logic [LINK_W-1:0]     mul_a;
  logic [PROD_W-1:0]     mul_res;
  logic [ADDR_BUS_W:0]   off_full;
  logic                  free_bad;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [LINK_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [LINK_W-1:0]     ram_rdata;

  logic                  div_start;
  fbpa_div_sts_t         div_sts;
  logic [ADDR_W-1:0]     div_quo;
  logic [DIV_W-1:0]      div_rem;

  assign act       = action_e'(s_axis_tuser);
  assign req_size  = s_axis_tdata[15:0];
  assign free_addr = s_axis_tdata[47:16];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // count above capacity acts as capacity
  assign used = (32'(count_q) > 32'(MAX_BLOCKS)) ? NULL_LINK : LINK_W'(count_q);

  assign cnt_inc   = cnt_q + LINK_W'(1);
  assign init_link = (cnt_inc < used) ? cnt_inc : NULL_LINK;

  // shared multiplier: pool span while idle, index times stride on alloc
  assign mul_a   = (state_q == S_AREAD) ? head_q : used;
  assign mul_res = PROD_W'(mul_a) * PROD_W'(stride_q);

  assign off_full = {1'b0, free_addr} - {1'b0, base_q};
  assign free_bad = (stride_q == '0) || lt_q || (CMP_W'(off_q) >= CMP_W'(prod_q));

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_addr_d     = m_addr_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q[ADDR_W-1:0];
    ram_wdata    = init_link;
    ram_re       = 1'b0;
    div_start    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_status_d = STAT_OK;
          res_addr_d   = '0;
          unique case (act)
            ACT_INIT: begin
              cnt_d = '0;
              if (used == '0) begin
                head_d  = NULL_LINK;
                state_d = S_RESP;
              end else begin
                head_d  = '0;
                state_d = S_INIT;
              end
            end
            ACT_ALLOC: begin
              if (req_size > stride_q) begin
                res_status_d = STAT_TOO_LARGE;
                state_d      = S_RESP;
              end else if (head_q >= NULL_LINK) begin
                res_status_d = STAT_EMPTY;
                state_d      = S_RESP;
              end else begin
                ram_re  = 1'b1;
                state_d = S_AREAD;
              end
            end
            ACT_FREE: begin
              state_d = S_FRNG;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_INIT: begin
        ram_we = 1'b1;
        cnt_d  = cnt_inc;
        if (cnt_inc >= used) begin
          state_d = S_RESP;
        end
      end
      S_AREAD: begin
        head_d  = ram_rdata;
        state_d = S_AADD;
      end
      S_AADD: begin
        res_addr_d = base_q + ADDR_BUS_W'(prod_q);
        state_d    = S_RESP;
      end
      S_FRNG: begin
        if (free_bad) begin
          res_status_d = STAT_BAD_FREE;
          state_d      = S_RESP;
        end else begin
          div_start = 1'b1;
          state_d   = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            ram_we    = 1'b1;
            ram_waddr = div_quo;
            ram_wdata = head_q;
            head_d    = LINK_W'(div_quo);
          end else begin
            res_status_d = STAT_BAD_FREE;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_addr_d   = res_addr_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= NULL_LINK;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RST;
      stride_q <= STRIDE_RST;
      count_q  <= COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASE:   base_q   <= cfg_data_i;
        CFG_STRIDE: stride_q <= cfg_data_i[STRIDE_W-1:0];
        CFG_COUNT:  count_q  <= cfg_data_i[COUNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    m_status_q   <= m_status_d;
    m_addr_q     <= m_addr_d;
    prod_q       <= mul_res;
    if (in_acc) begin
      off_q <= off_full[ADDR_BUS_W-1:0];
      lt_q  <= off_full[ADDR_BUS_W];
    end
  end

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  fbpa_div #(
    .QUO_W (ADDR_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (DIV_W'(off_q)),
    .divisor_i   (stride_q),
    .sts_o       (div_sts),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_addr_q;
  assign m_axis_tuser  = m_status_q;

  `FBPA_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE, "accepted item left sequencer idle")
  `FBPA_ASSERT_IMP(a_head_in_range, 1'b1, head_q <= NULL_LINK, "free head beyond null link")
  `FBPA_ASSERT_IMP(a_div_done_in_fdiv, div_sts.done, state_q == S_FDIV, "divider result outside free")
  `FBPA_ASSERT_IMP(a_ram_we_state, ram_we, (state_q == S_INIT) || (state_q == S_FDIV), "link write in wrong state")
  `FBPA_ASSERT_IMP(a_div_start_idle, div_start, !div_sts.busy, "divider restarted while busy")

endmodule

// File: test/tb_fixed_block_pool_allocator.sv
module tb_fixed_block_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int unsigned       NBLK             = MAX_BLOCKS_DEF;
  localparam logic [ACT_W-1:0]  ACT_NONE         = 2'd3;
  localparam int unsigned       CYCLE_LIMIT      = 2_000_000;
  localparam int unsigned       SINK_HOLD_CYCLES = 200;

  typedef struct packed {
    status_e               status;
    logic [ADDR_BUS_W-1:0] addr;
  } pool_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;
  logic [ACT_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [ADDR_BUS_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predicted pool state
  logic [ADDR_BUS_W-1:0] pool_base   = BASE_RST;
  logic [STRIDE_W-1:0]   pool_stride = STRIDE_RST;
  logic [COUNT_W-1:0]    pool_count  = COUNT_RST;
  logic [COUNT_W-1:0]    pool_head   = COUNT_W'(NBLK);
  logic [COUNT_W-1:0]    link_tbl [NBLK];

  pool_result_t pool_results_q [$];
  int unsigned  err_cnt   = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  sink_hold = 0;
  bit           idle_en   = 1'b1;

  fixed_block_pool_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6ns clk_i = 1'b1;
    #6ns clk_i = 1'b0;
  end

  function automatic pool_result_t pool_predict(input logic [ACT_W-1:0]      act,
                                                input logic [STRIDE_W-1:0]   size,
                                                input logic [ADDR_BUS_W-1:0] faddr);
    pool_result_t res;
    int unsigned  used;
    int unsigned  idx;
    logic [63:0]  off;
    logic [63:0]  span;
    res.status = STAT_OK;
    res.addr   = '0;
    used = (pool_count > NBLK) ? NBLK : 32'(pool_count);
    case (act)
      ACT_INIT: begin
        for (int unsigned i = 0; i < used; i++) begin
          link_tbl[i] = (i + 1 < used) ? COUNT_W'(i + 1) : COUNT_W'(NBLK);
        end
        pool_head = (used > 0) ? '0 : COUNT_W'(NBLK);
      end
      ACT_ALLOC: begin
        if (size > pool_stride) begin
          res.status = STAT_TOO_LARGE;
        end else if (pool_head >= NBLK) begin
          res.status = STAT_EMPTY;
        end else begin
          idx       = 32'(pool_head);
          pool_head = link_tbl[idx];
          res.addr  = pool_base + idx * pool_stride;
        end
      end
      ACT_FREE: begin
        if (pool_stride == '0 || faddr < pool_base) begin
          res.status = STAT_BAD_FREE;
        end else begin
          off  = 64'(faddr) - 64'(pool_base);
          span = 64'(pool_stride) * 64'(used);
          if (off >= span || (off % pool_stride) != 0) begin
            res.status = STAT_BAD_FREE;
          end else begin
            idx           = 32'(off / pool_stride);
            link_tbl[idx] = pool_head;
            pool_head     = COUNT_W'(idx);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_BASE:   pool_base   = data[ADDR_BUS_W-1:0];
      CFG_STRIDE: pool_stride = data[STRIDE_W-1:0];
      CFG_COUNT:  pool_count  = data[COUNT_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input  logic [ACT_W-1:0]      act,
                           input  logic [STRIDE_W-1:0]   size,
                           input  logic [ADDR_BUS_W-1:0] faddr,
                           output pool_result_t          res);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {faddr, size};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = pool_predict(act, size, faddr);
    pool_results_q.push_back(res);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pool_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // pool empty after reset, defaults for stride and count
  task automatic test_reset_defaults();
    pool_result_t r;
    send_item(ACT_ALLOC, 16'd64, 32'hFFFF_FFFF, r);
    send_item(ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF, r);
    send_item(ACT_FREE, 16'd0, 32'd65536, r);
    send_item(ACT_FREE, 16'd0, 32'd65472, r);
    send_item(ACT_ALLOC, 16'd0, 32'd0, r);
    send_item(ACT_ALLOC, 16'd64, 32'd0, r);
  endtask

  task automatic test_small_pool();
    pool_result_t r;
    wait_idle();
    write_reg(CFG_BASE, 32'h8000_0010);
    write_reg(CFG_STRIDE, 32'hDEAD_0030);
    write_reg(CFG_COUNT, 32'hFFFF_F803);
    send_item(ACT_INIT, '0, '0, r);
    send_item(ACT_ALLOC, 16'd48, '0, r);
    send_item(ACT_ALLOC, 16'd49, '0, r);
    send_item(ACT_ALLOC, 16'd1, '0, r);
    send_item(ACT_ALLOC, 16'd0, '0, r);
    send_item(ACT_ALLOC, 16'd48, '0, r);
    send_item(ACT_FREE, '0, 32'h8000_000F, r);
    send_item(ACT_FREE, '0, 32'h8000_003F, r);
    send_item(ACT_FREE, '0, 32'h8000_00A0, r);
    send_item(ACT_FREE, '0, 32'h8000_0040, r);
    send_item(ACT_ALLOC, 16'd48, '0, r);
  endtask

  task automatic test_stride_zero();
    pool_result_t r;
    wait_idle();
    write_reg(CFG_STRIDE, 32'h1234_0000);
    send_item(ACT_INIT, '0, '0, r);
    send_item(ACT_ALLOC, 16'd0, '0, r);
    send_item(ACT_ALLOC, 16'd1, '0, r);
    send_item(ACT_FREE, '0, 32'h8000_0010, r);
  endtask

  task automatic test_count_extremes();
    pool_result_t r;
    wait_idle();
    write_reg(CFG_BASE, 32'h0000_0000);
    write_reg(CFG_COUNT, 32'hFFFF_F800);
    send_item(ACT_INIT, '0, '0, r);
    send_item(ACT_ALLOC, 16'd0, '0, r);
    send_item(ACT_FREE, '0, 32'h0000_0000, r);
    wait_idle();
    write_reg(CFG_BASE, 32'hFFFF_FFF0);
    write_reg(CFG_STRIDE, 32'h0000_FFFF);
    write_reg(CFG_COUNT, 32'h0000_07FF);
    send_item(ACT_INIT, '0, '0, r);
    send_item(ACT_ALLOC, 16'hFFFF, '0, r);
    send_item(ACT_ALLOC, 16'd7, '0, r);
    send_item(ACT_FREE, '0, 32'hFFFF_FFFF, r);
    // stride change without a new init
    wait_idle();
    write_reg(CFG_STRIDE, 32'h0000_0010);
    send_item(ACT_ALLOC, 16'd16, '0, r);
  endtask

  task automatic test_output_backpressure();
    pool_result_t r;
    wait_idle();
    write_reg(CFG_STRIDE, 32'd32);
    write_reg(CFG_COUNT, 32'd8);
    send_item(ACT_INIT, '0, '0, r);
    sink_hold = SINK_HOLD_CYCLES;
    for (int i = 0; i < 6; i++) begin
      send_item(ACT_ALLOC, 16'd32, 32'($urandom()), r);
    end
  endtask

  task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
    pool_result_t          r;
    logic [STRIDE_W-1:0]   stride;
    logic [COUNT_W-1:0]    count;
    logic [ADDR_BUS_W-1:0] base;
    logic [ADDR_BUS_W-1:0] faddr;
    logic [STRIDE_W-1:0]   size;
    logic [ADDR_BUS_W-1:0] live_addrs [$];
    int unsigned           pick;
    int unsigned           k;
    for (int unsigned p = 0; p < phases; p++) begin
      wait_idle();
      idle_en = (p + 1 < phases);
      pick   = $urandom_range(0, 9);
      stride = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd1 : 16'($urandom_range(2, 300));
      pick   = $urandom_range(0, 9);
      count  = (pick == 0) ? 11'h7FF :
               (pick == 1) ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(1, 24));
      base   = $urandom();
      write_reg(CFG_BASE, base);
      write_reg(CFG_STRIDE, {16'($urandom()), stride});
      write_reg(CFG_COUNT, {21'($urandom()), count});
      // now and then keep the old list across the new settings
      if ($urandom_range(0, 9) != 0) begin
        send_item(ACT_INIT, 16'($urandom()), $urandom(), r);
        live_addrs.delete();
      end
      for (int unsigned n = 0; n < per_phase; n++) begin
        pick  = $urandom_range(0, 99);
        faddr = $urandom();
        size  = 16'($urandom());
        if (pick >= 45 && pick < 85 && live_addrs.size() > 0) begin
          k = $urandom_range(0, live_addrs.size() - 1);
          send_item(ACT_FREE, size, live_addrs[k], r);
          // a few stay listed so they get freed twice
          if (pick < 80) live_addrs.delete(k);
        end else if (pick >= 85 && pick < 90) begin
          send_item(ACT_FREE, size, faddr, r);
        end else if (pick >= 90 && pick < 93) begin
          faddr = base + $urandom_range(0, count + 1) * stride + $urandom_range(0, 1);
          send_item(ACT_FREE, size, faddr, r);
        end else if (pick >= 93 && pick < 96) begin
          send_item(ACT_INIT, size, faddr, r);
          live_addrs.delete();
        end else if (pick >= 96) begin
          send_item(ACT_NONE, size, faddr, r);
        end else begin
          k = $urandom_range(0, 9);
          if (k < 8) size = 16'($urandom_range(0, stride));
          else if (k == 8) size = stride + 16'd1;
          send_item(ACT_ALLOC, size, faddr, r);
          if (r.status == STAT_OK) live_addrs.push_back(r.addr);
        end
      end
    end
  endtask

  // result sink: random stalls, plus long holds on request
  initial begin : result_sink
    int unsigned n;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    pool_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pool_results_q.size() == 0) begin
        $error("unexpected transaction: status %0d, block_address %h",
               m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        want = pool_results_q.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata !== want.addr) begin
          $error("block_address: expected %h, got %h", want.addr, m_axis_tdata);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_fixed_block_pool_allocator: done, errors");
    $finish;
  end

  initial begin : stimulus
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_small_pool();
    test_stride_zero();
    test_count_extremes();
    test_output_backpressure();
    test_random_traffic(8, 200);
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_fixed_block_pool_allocator: done, clean");
    end else begin
      $display("tb_fixed_block_pool_allocator: done, errors");
    end
    $finish;
  end

endmodule
